@@ rtl/stb_pkg.sv @@
// Shared types and constants for the software timer bank.
// Holds the command record passed from front to back and the result codes.
// No dependencies.
package stb_pkg;

  localparam int MODE_W     = 3;
  localparam int ID_W       = 8;
  localparam int MS_W       = 24;
  localparam int PERIOD_W   = 22;
  localparam int TIME_W     = 32;
  localparam int STATUS_W   = 2;
  localparam int SDATA_W    = 40;
  localparam int MDATA_W    = 16;

  localparam int MAX_RESULTS = 16;
  localparam int CNT_W       = $clog2(MAX_RESULTS + 1);
  localparam int QUEUE_DEPTH = 4;

  // floor(ms * 160 / 1000) = floor((ms * 4) / 25), done as a multiply by
  // ceil(2^31 / 25) and a shift; exact for every 26-bit dividend.
  localparam int                 X_W      = MS_W + 2;
  localparam int                 RECIP_W  = 27;
  localparam int                 RECIP_SH = 31;
  localparam logic [RECIP_W-1:0] RECIP_M  = 27'd85899346;
  localparam int                 PROD_W   = X_W + RECIP_W;

  typedef enum logic [MODE_W-1:0] {
    K_TICK   = 3'd0,
    K_ADD    = 3'd1,
    K_START  = 3'd2,
    K_STOP   = 3'd3,
    K_DELETE = 3'd4
  } kind_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK     = 2'd0,
    ST_FULL   = 2'd1,
    ST_BAD_ID = 2'd2
  } status_t;

  typedef struct packed {
    kind_t                kind;
    logic [ID_W-1:0]      id;
    logic [PERIOD_W-1:0]  period;
    logic                 one_shot;
  } cmd_t;

  typedef struct packed {
    logic                 one_shot;
    logic [PERIOD_W-1:0]  period;
  } slot_cfg_t;

  localparam int CFG_W = $bits(slot_cfg_t);
  localparam int CMD_W = $bits(cmd_t);

endpackage

@@ rtl/stb_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
// Used for the per-slot timing tables. No dependencies.
module stb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/stb_front.sv @@
// Front end: takes requests, drops unused modes and converts the add period
// from milliseconds to ticks. Depends on stb_pkg.
module stb_front
  import stb_pkg::*;
(
  input  logic               s_tvalid,
  output logic               s_tready,
  input  logic [SDATA_W-1:0] s_tdata,
  input  logic [MODE_W-1:0]  s_tuser,
  input  logic               q_full,
  output logic               q_push,
  output cmd_t               q_cmd
);

  logic [MS_W-1:0]   ms;
  logic [PROD_W-1:0] prod;
  logic              mode_ok;

  always_comb begin
    ms      = s_tdata[ID_W +: MS_W];
    prod    = PROD_W'({ms, 2'b00}) * PROD_W'(RECIP_M);
    mode_ok = s_tuser <= MODE_W'(K_DELETE);

    q_cmd.kind     = kind_t'(s_tuser);
    q_cmd.id       = s_tdata[ID_W-1:0];
    q_cmd.period   = prod[RECIP_SH +: PERIOD_W];
    q_cmd.one_shot = s_tdata[ID_W + MS_W];

    s_tready = !q_full;
    q_push   = s_tvalid && !q_full && mode_ok;
  end

endmodule

@@ rtl/stb_queue.sv @@
// Short command queue between the front end and the timer engine.
// Depends on stb_pkg.
module stb_queue
  import stb_pkg::*;
#(
  parameter int DEPTH = 4
) (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  input  logic pop,
  output cmd_t pop_cmd,
  output logic empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  cmd_t            entry [DEPTH];
  logic [AW-1:0]   wr_ptr;
  logic [AW-1:0]   rd_ptr;
  logic [AW:0]     count;

  assign full    = count == (AW + 1)'(DEPTH);
  assign empty   = count == '0;
  assign pop_cmd = entry[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        entry[wr_ptr] <= push_cmd;
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
      end
      if (push && !pop) begin
        count <= count + (AW + 1)'(1);
      end else if (pop && !push) begin
        count <= count - (AW + 1)'(1);
      end
    end
  end

endmodule

@@ rtl/stb_back.sv @@
// Timer engine (needs stb_pkg, stb_ram): holds the tick counter and slot flags,
// scans the slot table one slot a cycle unless output stalls, drives results.
module stb_back
  import stb_pkg::*;
#(
  parameter int NUM_TIMERS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               q_empty,
  input  cmd_t               q_cmd,
  output logic               q_pop,
  output logic               m_tvalid,
  input  logic               m_tready,
  output logic [MDATA_W-1:0] m_tdata,
  output logic               m_tuser,
  output logic               m_tlast
);

  localparam int IW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_SCAN  = 5'b00010,
    S_FLUSH = 5'b00100,
    S_FIND  = 5'b01000,
    S_CMD   = 5'b10000
  } state_t;

  state_t                state;
  state_t                state_next;
  cmd_t                  cmd;
  logic [IW-1:0]         idx;
  logic [IW-1:0]         idx_next;
  logic [TIME_W-1:0]     now;
  logic [NUM_TIMERS-1:0] in_use;
  logic [NUM_TIMERS-1:0] running;
  logic                  pend_valid;
  logic [IW-1:0]         pend_slot;
  logic [CNT_W-1:0]      fire_cnt;
  logic [ID_W-1:0]       out_slot;
  status_t               out_status;

  logic [TIME_W-1:0]     st_rd;
  slot_cfg_t             cfg_rd;
  slot_cfg_t             cfg_wr;
  logic                  time_we;
  logic [IW-1:0]         time_waddr;
  logic                  cfg_we;

  logic                  out_free;
  logic                  out_load;
  logic                  idx_last;
  logic                  cur_hit;
  logic                  scan_go;
  logic                  scan_fire;
  logic                  scan_done;
  logic                  flush_out;
  logic                  find_free;
  logic                  find_end;
  logic                  cmd_go;
  logic                  id_ok;
  logic [IW-1:0]         id_idx;

  always_comb begin
    out_free  = !m_tvalid || m_tready;
    idx_last  = idx == IW'(NUM_TIMERS - 1);
    cur_hit   = in_use[idx] && running[idx] &&
                ((now - st_rd) >= TIME_W'(cfg_rd.period));
    scan_go   = (state == S_SCAN) && (!cur_hit || !pend_valid || out_free);
    scan_fire = scan_go && cur_hit;
    scan_done = scan_go &&
                (idx_last || (cur_hit && fire_cnt == CNT_W'(MAX_RESULTS - 1)));
    flush_out = (state == S_FLUSH) && pend_valid && out_free;
    find_free = !in_use[idx];
    find_end  = (state == S_FIND) && (find_free || idx_last) && out_free;
    cmd_go    = (state == S_CMD) && out_free;
    out_load  = (scan_fire && pend_valid) || flush_out || find_end || cmd_go;
    id_ok     = {1'b0, cmd.id} < (ID_W + 1)'(NUM_TIMERS);
    id_idx    = cmd.id[IW-1:0];
    q_pop     = (state == S_IDLE) && !q_empty;

    cfg_wr.one_shot = cmd.one_shot;
    cfg_wr.period   = cmd.period;
    cfg_we          = find_end && find_free;
    time_we         = (scan_fire && !cfg_rd.one_shot) || cfg_we ||
                      (cmd_go && id_ok && cmd.kind == K_START);
    time_waddr      = (state == S_CMD) ? id_idx : idx;

    state_next = state;
    idx_next   = idx;
    unique case (state)
      S_IDLE: begin
        idx_next = '0;
        if (q_pop) begin
          unique case (q_cmd.kind)
            K_TICK:  state_next = S_SCAN;
            K_ADD:   state_next = S_FIND;
            default: state_next = S_CMD;
          endcase
        end
      end
      S_SCAN: begin
        if (scan_done) begin
          state_next = S_FLUSH;
        end else if (scan_go) begin
          idx_next = idx + IW'(1);
        end
      end
      S_FLUSH: begin
        if (!pend_valid || out_free) begin
          state_next = S_IDLE;
        end
      end
      S_FIND: begin
        if (find_end) begin
          state_next = S_IDLE;
        end else if (!find_free && !idx_last) begin
          idx_next = idx + IW'(1);
        end
      end
      S_CMD: begin
        if (cmd_go) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  stb_ram #(
    .WIDTH (TIME_W),
    .DEPTH (NUM_TIMERS)
  ) u_time_ram (
    .clk   (clk),
    .we    (time_we),
    .waddr (time_waddr),
    .wdata (now),
    .raddr (idx_next),
    .rdata (st_rd)
  );

  stb_ram #(
    .WIDTH (CFG_W),
    .DEPTH (NUM_TIMERS)
  ) u_cfg_ram (
    .clk   (clk),
    .we    (cfg_we),
    .waddr (idx),
    .wdata (cfg_wr),
    .raddr (idx_next),
    .rdata (cfg_rd)
  );

  assign m_tdata = {(MDATA_W - ID_W - STATUS_W)'(0), out_status, out_slot};

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      idx        <= '0;
      now        <= TIME_W'(1);
      in_use     <= '0;
      running    <= '0;
      pend_valid <= 1'b0;
      fire_cnt   <= '0;
      m_tvalid   <= 1'b0;
    end else begin
      state    <= state_next;
      idx      <= idx_next;
      m_tvalid <= out_load || (m_tvalid && !m_tready);

      if (q_pop) begin
        cmd      <= q_cmd;
        fire_cnt <= '0;
        if (q_cmd.kind == K_TICK) begin
          now <= now + TIME_W'(1);
        end
      end

      if (scan_fire) begin
        if (pend_valid) begin
          out_slot   <= ID_W'(pend_slot);
          out_status <= ST_OK;
          m_tuser    <= 1'b1;
          m_tlast    <= 1'b0;
        end
        pend_valid <= 1'b1;
        pend_slot  <= idx;
        fire_cnt   <= fire_cnt + CNT_W'(1);
        if (cfg_rd.one_shot) begin
          running[idx] <= 1'b0;
        end
      end

      if (flush_out) begin
        out_slot   <= ID_W'(pend_slot);
        out_status <= ST_OK;
        m_tuser    <= 1'b1;
        m_tlast    <= 1'b1;
        pend_valid <= 1'b0;
      end

      if (find_end) begin
        m_tuser  <= 1'b0;
        m_tlast  <= 1'b1;
        if (find_free) begin
          out_slot     <= ID_W'(idx);
          out_status   <= ST_OK;
          in_use[idx]  <= 1'b1;
          running[idx] <= 1'b1;
        end else begin
          out_slot   <= '0;
          out_status <= ST_FULL;
        end
      end

      if (cmd_go) begin
        out_slot   <= cmd.id;
        out_status <= id_ok ? ST_OK : ST_BAD_ID;
        m_tuser    <= 1'b0;
        m_tlast    <= 1'b1;
        if (id_ok) begin
          unique case (cmd.kind)
            K_START:  running[id_idx] <= 1'b1;
            K_STOP:   running[id_idx] <= 1'b0;
            K_DELETE: in_use[id_idx]  <= 1'b0;
            default: ;
          endcase
        end
      end
    end
  end

endmodule

@@ rtl/software_timer_bank.sv @@
// Software timer bank: a table of periodic and one-shot timers driven by ticks.
// Top level; depends on stb_pkg, stb_front, stb_queue, stb_back, stb_ram.
// Requests arrive on the s_ channel: s_tuser carries the mode (tick, add,
// start, stop, delete), s_tdata the slot id, the period in ms and the
// one-shot flag. Results leave on the m_ channel: m_tdata holds the slot and
// status, m_tuser is high for a timer expiry and m_tlast marks the final
// result of a request. A tick gives one result per expired slot, at most 16,
// and none when nothing expires; every other valid request gives one result.
// Requests are taken while the four-entry queue has room, so the sender
// runs ahead of the engine. The engine handles one request at a time.
// A tick scans the slot table, reading one table entry a cycle unless a
// stalled result holds the scan; an add searches for the lowest free slot.
// Tick results trail the scan by one fired slot: each is sent when the next
// expired slot is found, and the last one once the scan ends.
// When the receiver stalls, the result register holds its item and the
// engine waits; the queue then fills and s_tready drops.
// Reset clears the queue, the slot flags and the result register and sets the
// tick counter to one; the slot tables need no clearing.
module software_timer_bank
  import stb_pkg::*;
#(
  parameter int NUM_TIMERS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  output logic               s_tready,
  input  logic [SDATA_W-1:0] s_tdata,   // timer_id, period_ms, single_shot
  input  logic [MODE_W-1:0]  s_tuser,   // mode
  output logic               m_tvalid,
  input  logic               m_tready,
  output logic [MDATA_W-1:0] m_tdata,   // slot, status
  output logic               m_tuser,   // fired
  output logic               m_tlast
);

  logic q_push;
  logic q_full;
  logic q_pop;
  logic q_empty;
  cmd_t push_cmd;
  cmd_t pop_cmd;

  stb_front u_front (
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_cmd    (push_cmd)
  );

  stb_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .pop_cmd  (pop_cmd),
    .empty    (q_empty)
  );

  stb_back #(
    .NUM_TIMERS (NUM_TIMERS)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .q_empty  (q_empty),
    .q_cmd    (pop_cmd),
    .q_pop    (q_pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

endmodule

@@ tb/tb.sv @@
// Self-checking testbench for software_timer_bank: drives tick, add, start, stop
// and delete requests and checks every result against a built-in timer table.
// Depends on stb_pkg and software_timer_bank.
`timescale 1ns / 1ps

module tb;
  import stb_pkg::*;

  localparam int NUM_TIMERS = 16;
  localparam int TICK_NUM   = 160;
  localparam int TICK_DEN   = 1000;
  localparam int PER_PHASE  = 46;

  typedef struct {
    logic [ID_W-1:0] slot;
    status_t         status;
    logic            fired;
    logic            last;
  } timer_result_t;

  class timer_expiry_tracker;
    timer_result_t       due_results[$];
    int                  mismatches;
    logic [TIME_W-1:0]   now_ticks;
    logic                in_use[NUM_TIMERS];
    logic                running[NUM_TIMERS];
    logic                one_shot[NUM_TIMERS];
    logic [PERIOD_W-1:0] period_ticks[NUM_TIMERS];
    logic [TIME_W-1:0]   start_time[NUM_TIMERS];

    function new();
      mismatches = 0;
      now_ticks = 1;
      for (int i = 0; i < NUM_TIMERS; i++) begin
        in_use[i] = 1'b0;
        running[i] = 1'b0;
        one_shot[i] = 1'b0;
        period_ticks[i] = '0;
        start_time[i] = '0;
      end
    endfunction

    function void push_result(logic [ID_W-1:0] slot, status_t status, logic fired,
                              logic last);
      timer_result_t r;
      r.slot = slot;
      r.status = status;
      r.fired = fired;
      r.last = last;
      due_results.push_back(r);
    endfunction

    function void note_request(logic [MODE_W-1:0] mode, logic [ID_W-1:0] id,
                               logic [MS_W-1:0] ms, logic single);
      int n;
      int free_slot;
      logic [TIME_W-1:0] elapsed;
      logic [TIME_W-1:0] scaled;
      n = 0;
      free_slot = NUM_TIMERS;
      if (mode == K_TICK) begin
        now_ticks = now_ticks + 1;
        for (int i = 0; i < NUM_TIMERS && n < MAX_RESULTS; i++) begin
          elapsed = now_ticks - start_time[i];
          if (in_use[i] && running[i] && elapsed >= TIME_W'(period_ticks[i])) begin
            push_result(ID_W'(i), ST_OK, 1'b1, 1'b0);
            n++;
            if (one_shot[i]) running[i] = 1'b0;
            else start_time[i] = now_ticks;
          end
        end
        if (n > 0) due_results[due_results.size() - 1].last = 1'b1;
      end else if (mode == K_ADD) begin
        for (int i = NUM_TIMERS - 1; i >= 0; i--)
          if (!in_use[i]) free_slot = i;
        if (free_slot == NUM_TIMERS) begin
          push_result('0, ST_FULL, 1'b0, 1'b1);
        end else begin
          scaled = (TIME_W'(ms) * TICK_NUM) / TICK_DEN;
          period_ticks[free_slot] = scaled[PERIOD_W-1:0];
          one_shot[free_slot] = single;
          in_use[free_slot] = 1'b1;
          running[free_slot] = 1'b1;
          start_time[free_slot] = now_ticks;
          push_result(ID_W'(free_slot), ST_OK, 1'b0, 1'b1);
        end
      end else if (mode == K_START || mode == K_STOP || mode == K_DELETE) begin
        if (id >= NUM_TIMERS) begin
          push_result(id, ST_BAD_ID, 1'b0, 1'b1);
        end else begin
          if (mode == K_START) begin
            running[id] = 1'b1;
            start_time[id] = now_ticks;
          end else if (mode == K_STOP) begin
            running[id] = 1'b0;
          end else begin
            in_use[id] = 1'b0;
          end
          push_result(id, ST_OK, 1'b0, 1'b1);
        end
      end
    endfunction

    function void check_result(logic [ID_W-1:0] slot, logic [STATUS_W-1:0] status,
                               logic fired, logic last);
      timer_result_t want;
      if (due_results.size() == 0) begin
        $error("unexpected result: slot %0d status %0d fired %0b last %0b",
               slot, status, fired, last);
        mismatches++;
      end else begin
        want = due_results.pop_front();
        if (slot !== want.slot) begin
          $error("slot: expected %0d, got %0d", want.slot, slot);
          mismatches++;
        end
        if (status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, status);
          mismatches++;
        end
        if (fired !== want.fired) begin
          $error("fired: expected %0b, got %0b", want.fired, fired);
          mismatches++;
        end
        if (last !== want.last) begin
          $error("last: expected %0b, got %0b", want.last, last);
          mismatches++;
        end
      end
    endfunction

    function void report_unmet();
      foreach (due_results[i]) begin
        $error("missing result: slot %0d status %0d fired %0b last %0b",
               due_results[i].slot, due_results[i].status, due_results[i].fired,
               due_results[i].last);
        mismatches++;
      end
      due_results.delete();
    endfunction
  endclass

  logic               clk;
  logic               rst;
  logic               s_tvalid;
  logic               s_tready;
  logic [SDATA_W-1:0] s_tdata;
  logic [MODE_W-1:0]  s_tuser;
  logic               m_tvalid;
  logic               m_tready;
  logic [MDATA_W-1:0] m_tdata;
  logic               m_tuser;
  logic               m_tlast;

  int                  sender_idle_pct;
  int                  receiver_idle_pct;
  timer_expiry_tracker tracker;

  software_timer_bank #(
    .NUM_TIMERS(NUM_TIMERS)
  ) dut (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser),
    .m_tlast (m_tlast)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  initial begin
    #10ms;
    $display("Mismatches found");
    $finish;
  end

  always @(negedge clk) begin
    m_tready = ($urandom_range(0, 99) >= receiver_idle_pct);
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready)
      tracker.check_result(m_tdata[ID_W-1:0], m_tdata[ID_W+STATUS_W-1:ID_W], m_tuser,
                           m_tlast);
  end

  task automatic send_request(logic [MODE_W-1:0] mode, logic [ID_W-1:0] id,
                              logic [MS_W-1:0] ms, logic single);
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      @(negedge clk);
      s_tvalid = 1'b0;
    end
    @(negedge clk);
    s_tvalid = 1'b1;
    s_tdata = {7'b0, single, ms, id};
    s_tuser = mode;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    tracker.note_request(mode, id, ms, single);
  endtask

  task automatic send_random_request(output bit counted);
    int roll;
    logic [MODE_W-1:0] mode;
    logic [ID_W-1:0] id;
    logic [MS_W-1:0] ms;
    roll = $urandom_range(0, 99);
    counted = 1'b1;
    if (roll < 5) begin
      mode = MODE_W'($urandom_range(5, 7));
      counted = 1'b0;
    end else if (roll < 45) mode = K_TICK;
    else if (roll < 62) mode = K_ADD;
    else if (roll < 74) mode = K_START;
    else if (roll < 86) mode = K_STOP;
    else mode = K_DELETE;
    id = ($urandom_range(0, 99) < 85) ? ID_W'($urandom_range(0, NUM_TIMERS - 1))
                                       : ID_W'($urandom_range(0, 255));
    roll = $urandom_range(0, 9);
    if (roll < 7) ms = MS_W'($urandom_range(0, 200));
    else if (roll < 9) ms = MS_W'($urandom_range(0, 6));
    else ms = MS_W'($urandom);
    send_request(mode, id, ms, 1'($urandom));
  endtask

  initial begin
    bit counted;
    int sent;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = '0;
    m_tready = 1'b0;
    sender_idle_pct = 28;
    receiver_idle_pct = 61;
    tracker = new();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Empty tick, bad ids, a start on a free slot and ignored modes.
    send_request(K_TICK, 8'd0, 24'd0, 1'b0);
    send_request(K_START, 8'd255, 24'd0, 1'b0);
    send_request(K_STOP, 8'd16, 24'd0, 1'b0);
    send_request(K_DELETE, 8'd128, 24'd0, 1'b0);
    send_request(K_START, 8'd5, 24'd0, 1'b0);
    send_request(3'd5, 8'd0, 24'd0, 1'b0);
    send_request(3'd7, 8'd255, 24'hFFFFFF, 1'b1);

    // Fill the table with zero-period timers, overflow it, then fire all of them.
    for (int i = 0; i < NUM_TIMERS; i++)
      send_request(K_ADD, 8'd0, MS_W'(i % 7), 1'b0);
    send_request(K_ADD, 8'd0, 24'd50, 1'b1);
    send_request(K_TICK, 8'd0, 24'd0, 1'b0);

    // Delete keeps the running flag; re-add with the largest period.
    send_request(K_DELETE, 8'd3, 24'd0, 1'b0);
    send_request(K_STOP, 8'd4, 24'd0, 1'b0);
    send_request(K_ADD, 8'd0, 24'hFFFFFF, 1'b1);
    send_request(K_TICK, 8'd0, 24'd0, 1'b0);

    for (int phase = 0; phase < 3; phase++) begin
      sender_idle_pct = (phase == 0) ? 28 : (phase == 1) ? 61 : 0;
      receiver_idle_pct = (phase == 0) ? 61 : (phase == 1) ? 28 : 0;
      sent = 0;
      while (sent < PER_PHASE) begin
        send_random_request(counted);
        if (counted) sent++;
      end
    end

    @(negedge clk);
    s_tvalid = 1'b0;
    while (tracker.due_results.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    tracker.report_unmet();
    if (tracker.mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

@@ software_timer_bank.f @@
rtl/stb_pkg.sv
rtl/stb_ram.sv
rtl/stb_front.sv
rtl/stb_queue.sv
rtl/stb_back.sv
rtl/software_timer_bank.sv
tb/tb.sv
